@@ rtl/core/vn3d_pkg.sv @@
// vn3d_pkg: shared constants for the 3d vector normalizer
// no dependencies; used by vector_normalizer_3d_unit and its checker
package vn3d_pkg;

  localparam int OUT_W       = 16;           // width of each result field
  localparam int OUT_TDATA_W = 4 * OUT_W;    // unit_x, unit_y, unit_z, magnitude
  localparam int OUT_TUSER_W = 1;            // was_zero

  localparam logic [OUT_W-1:0] MAG_MAX  = 16'hFFFF;
  localparam logic [OUT_W-1:0] UNIT_MAX = 16'h7FFF;

endpackage

@@ rtl/core/vector_normalizer_3d_unit.sv @@
// vector_normalizer_3d_unit: 3d vector normalizer, top level
// depends on vn3d_pkg
//
// pipeline: stages a, b and c, then K bit stages, K = max(IN_WIDTH, OUT_FRAC_BITS + 2), of the
//   bit-per-stage square root / divide chain, then the output register
// throughput: one vector per cycle; the whole pipe advances whenever the output
//   register is empty or being taken
// reset: rst (synchronous, active high) clears every stage valid bit; payload is not reset
module vector_normalizer_3d_unit #(
  parameter int IN_WIDTH      = 16,
  parameter int OUT_FRAC_BITS = 14
) (
  input  logic clk,
  input  logic rst,
  // input vectors
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [((3*IN_WIDTH+7)/8)*8-1:0]     s_tdata,   // comp_x, comp_y, comp_z, zero pad
  // normalized vectors
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [vn3d_pkg::OUT_TDATA_W-1:0]    m_tdata,   // unit_x, unit_y, unit_z, magnitude
  output logic [vn3d_pkg::OUT_TUSER_W-1:0]    m_tuser    // was_zero
);

  localparam int W   = IN_WIDTH;
  localparam int F   = OUT_FRAC_BITS;
  localparam int VW  = F + 2;                 // unscaled unit result, before the final halving
  localparam int K   = (W > VW) ? W : VW;     // number of bit stages
  localparam int SW  = 2 * W;                 // sum of squares
  localparam int QW  = VW + SW;               // v * sum
  localparam int NW  = SW + 2 * VW;           // m^2 << (2F+2) and v^2 * sum
  localparam int SH  = 2 * F + 2;
  localparam int OW  = vn3d_pkg::OUT_W;
  localparam logic [OW-1:0] UNIT_ONE = OW'(64'(1) << F);

  // the whole pipe moves together; it stalls only when the output beat is held
  logic en;
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  // ---------------- stage a: magnitude and sign of each component
  logic         a_valid;
  logic [W-1:0] a_mag [3];
  logic [2:0]   a_neg;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (en) begin
      a_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        a_neg[i] <= s_tdata[i*W + W - 1];
        // two's complement negate; the most negative code becomes 2^(W-1)
        a_mag[i] <= s_tdata[i*W + W - 1] ? W'(~s_tdata[i*W +: W] + 1'b1) : s_tdata[i*W +: W];
      end
    end
  end

  // ---------------- stage b: squares
  logic          b_valid;
  logic [SW-1:0] b_sq [3];
  logic [2:0]    b_neg;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (en) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_neg <= a_neg;
      for (int i = 0; i < 3; i++) begin
        b_sq[i] <= SW'(a_mag[i]) * SW'(a_mag[i]);
      end
    end
  end

  // ---------------- stage c: sum of squares, scaled numerators, zero detect
  // stage arrays below are indexed by bit stage; index 0 is the output of stage c
  logic          it_valid [0:K];
  logic [SW-1:0] it_sum   [0:K];
  logic [NW-1:0] it_num   [0:K][3];
  logic [NW-1:0] it_p     [0:K][3];   // v^2 * sum
  logic [QW-1:0] it_q     [0:K][3];   // v * sum
  logic [VW-1:0] it_v     [0:K][3];   // partial unit root
  logic [SW-1:0] it_r2    [0:K];      // r^2
  logic [W-1:0]  it_r     [0:K];      // partial length root
  logic [2:0]    it_neg   [0:K];
  logic          it_zero  [0:K];

  logic [SW-1:0] c_sum;
  assign c_sum = b_sq[0] + b_sq[1] + b_sq[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      it_valid[0] <= 1'b0;
    end else if (en) begin
      it_valid[0] <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      it_sum[0]  <= c_sum;
      it_zero[0] <= (c_sum == '0);
      it_neg[0]  <= b_neg;
      it_r2[0]   <= '0;
      it_r[0]    <= '0;
      for (int i = 0; i < 3; i++) begin
        it_num[0][i] <= NW'(b_sq[i]) << SH;
        it_p[0][i]   <= '0;
        it_q[0][i]   <= '0;
        it_v[0][i]   <= '0;
      end
    end
  end

  // ---------------- bit stages: one result bit per stage, most significant first
  // unit: v = floor(sqrt(m^2 * 2^(2F+2) / sum)), found by testing (v+b)^2*sum <= num
  //       with v^2*sum and v*sum kept up to date by shifts and adds only
  // length: r = floor(sqrt(sum)), found by testing (r+b)^2 <= sum
  for (genvar j = 0; j < K; j++) begin : g_bit
    localparam int KB = K - 1 - j;

    logic [NW-1:0]   p_try  [3];
    logic [2:0]      u_take;
    logic [SW+1:0]   r2_try;
    logic            r_take;

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        if (KB < VW) begin
          p_try[i]  = it_p[j][i] + (NW'(it_q[j][i]) << (KB + 1)) + (NW'(it_sum[j]) << (2 * KB));
          u_take[i] = (p_try[i] <= it_num[j][i]);
        end else begin
          p_try[i]  = it_p[j][i];
          u_take[i] = 1'b0;
        end
      end
      if (KB < W) begin
        r2_try = (SW+2)'(it_r2[j]) + ((SW+2)'(it_r[j]) << (KB + 1)) + ((SW+2)'(1) << (2 * KB));
        r_take = (r2_try <= (SW+2)'(it_sum[j]));
      end else begin
        r2_try = (SW+2)'(it_r2[j]);
        r_take = 1'b0;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        it_valid[j+1] <= 1'b0;
      end else if (en) begin
        it_valid[j+1] <= it_valid[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        it_sum[j+1]  <= it_sum[j];
        it_zero[j+1] <= it_zero[j];
        it_neg[j+1]  <= it_neg[j];
        for (int i = 0; i < 3; i++) begin
          it_num[j+1][i] <= it_num[j][i];
          if (u_take[i]) begin
            it_p[j+1][i] <= p_try[i];
            it_q[j+1][i] <= it_q[j][i] + (QW'(it_sum[j]) << KB);
            it_v[j+1][i] <= it_v[j][i] | (VW'(64'(1) << KB));
          end else begin
            it_p[j+1][i] <= it_p[j][i];
            it_q[j+1][i] <= it_q[j][i];
            it_v[j+1][i] <= it_v[j][i];
          end
        end
        if (r_take) begin
          it_r2[j+1] <= SW'(r2_try);
          it_r[j+1]  <= it_r[j] | (W'(64'(1) << KB));
        end else begin
          it_r2[j+1] <= it_r2[j];
          it_r[j+1]  <= it_r[j];
        end
      end
    end
  end

  // ---------------- output stage: rounding, saturation, sign, zero vector
  logic [SW-1:0]    len;
  logic [SW+OW-1:0] len_ext;
  logic [OW-1:0]    mag_out;
  logic [VW-1:0]    q_unit [3];
  logic [VW+OW-1:0] q_ext  [3];
  logic [OW-1:0]    u_mag  [3];
  logic [OW-1:0]    u_out  [3];

  always_comb begin
    // round to nearest: step up when sum - r^2 exceeds r
    len     = ((it_sum[K] - it_r2[K]) > SW'(it_r[K])) ? SW'(it_r[K]) + 1'b1 : SW'(it_r[K]);
    len_ext = (SW+OW)'(len);
    mag_out = (len_ext > (SW+OW)'(vn3d_pkg::MAG_MAX)) ? vn3d_pkg::MAG_MAX : OW'(len);
    for (int i = 0; i < 3; i++) begin
      // halve the doubled-scale root with rounding
      q_unit[i] = VW'(((VW+1)'(it_v[K][i]) + 1'b1) >> 1);
      q_ext[i]  = (VW+OW)'(q_unit[i]);
      u_mag[i]  = (q_ext[i] > (VW+OW)'(vn3d_pkg::UNIT_MAX)) ? vn3d_pkg::UNIT_MAX : OW'(q_unit[i]);
      u_out[i]  = it_neg[K][i] ? OW'(~u_mag[i] + 1'b1) : u_mag[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= it_valid[K];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (it_zero[K]) begin
        // zero vector: default direction (1,0,0), length zero
        m_tdata <= {{OW{1'b0}}, {OW{1'b0}}, {OW{1'b0}}, UNIT_ONE};
        m_tuser <= 1'b1;
      end else begin
        m_tdata <= {mag_out, u_out[2], u_out[1], u_out[0]};
        m_tuser <= 1'b0;
      end
    end
  end

endmodule

@@ rtl/core/vn3d_checker.sv @@
// vn3d_checker: port-level checks for vector_normalizer_3d_unit, with its bind
// depends on vn3d_pkg
module vn3d_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             m_tvalid,
  input logic                             m_tready,
  input logic [vn3d_pkg::OUT_TDATA_W-1:0] m_tdata,
  input logic [vn3d_pkg::OUT_TUSER_W-1:0] m_tuser
);

  // held output beat keeps its payload
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("output beat changed while stalled");

  // no output beat right after reset
  a_reset: assert property (@(posedge clk) $past(rst) |-> !m_tvalid)
    else $error("output valid after reset");

  // zero vector gives zero y, z and length
  a_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata[31:16] == '0 && m_tdata[47:32] == '0
                               && m_tdata[63:48] == '0)
    else $error("zero vector result not default");

  // any nonzero vector has a nonzero length
  a_len: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tdata[63:48] != '0)
    else $error("nonzero vector with zero length");

endmodule

bind vector_normalizer_3d_unit vn3d_checker u_vn3d_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

@@ test/tb_vector_normalizer_3d_unit.sv @@
// tb_vector_normalizer_3d_unit: self-checking stream testbench for the 3d vector normalizer
// depends on vn3d_pkg and vector_normalizer_3d_unit; bit-exact predictor, random stalls
`timescale 1ns / 100ps

module tb_vector_normalizer_3d_unit;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 40;  // idle time before the final check, with margin for the pipe to drain

  typedef struct packed {
    logic [15:0] ux;
    logic [15:0] uy;
    logic [15:0] uz;
    logic [15:0] mag;
    logic        zero;
  } norm_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [vn3d_pkg::OUT_TDATA_W-1:0] m_tdata;
  logic [vn3d_pkg::OUT_TUSER_W-1:0] m_tuser;

  logic [47:0] vec_pending[$];   // vectors waiting to be offered
  norm_t       norm_expected[$]; // results owed by the block
  int errors = 0;
  int cycles = 0;
  bit no_idle = 0;               // phases with back-to-back beats
  int long_hold_req = 0;
  int long_hold_seen = 0;
  int src_gap = 0;
  int sink_hold = 0;

  vector_normalizer_3d_unit i_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // bitwise integer square root, floor
  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic norm_t normalize(logic [47:0] vec);
    norm_t r;
    longint unsigned m[3];
    bit neg[3];
    longint unsigned sum, root, len, v, q;
    logic [15:0] c;
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      c = vec[16*i +: 16];
      neg[i] = c[15];
      m[i] = c[15] ? (64'd65536 - c) : c;
      sum += m[i] * m[i];
    end
    if (sum == 0) return '{16'd16384, 16'd0, 16'd0, 16'd0, 1'b1};
    root = int_sqrt(sum);
    len = (sum - root * root > root) ? root + 1 : root;
    if (len > 65535) len = 65535;
    r.mag = len[15:0];
    r.zero = 1'b0;
    for (int i = 0; i < 3; i++) begin
      // twice the unit value with one extra bit, then round half away from zero
      v = int_sqrt(((m[i] * m[i]) << 30) / sum);
      q = (v + 1) >> 1;
      if (q > 32767) q = 32767;
      if (neg[i]) q = -q;
      case (i)
        0: r.ux = q[15:0];
        1: r.uy = q[15:0];
        default: r.uz = q[15:0];
      endcase
    end
    return r;
  endfunction

  function automatic int pick_gap();
    int p;
    p = $urandom_range(99);
    if (p < 70) return 0;
    if (p < 95) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // driver: offers pending vectors, logs each accepted beat
  always @(posedge clk) begin
    bit nv;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) norm_expected.push_back(normalize(s_tdata));
      if (s_tvalid && !s_tready) begin
        nv = 1'b1;  // hold the beat
      end else if (src_gap > 0) begin
        src_gap--;
        nv = 1'b0;
      end else if (vec_pending.size() > 0) begin
        nv = 1'b1;
        s_tdata <= vec_pending.pop_front();
        src_gap = no_idle ? 0 : pick_gap();
      end else begin
        nv = 1'b0;
      end
      s_tvalid <= nv;
    end
  end

  // monitor: random backpressure, checks each result beat
  always @(posedge clk) begin
    norm_t exp_r, got;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = {m_tdata[15:0], m_tdata[31:16], m_tdata[47:32], m_tdata[63:48], m_tuser[0]};
        if (norm_expected.size() == 0) begin
          $display("%0t: unexpected beat, actual %h", $time, got);
          errors++;
        end else begin
          exp_r = norm_expected.pop_front();
          if (got.ux !== exp_r.ux) begin
            $display("%0t: unit_x expected %h actual %h", $time, exp_r.ux, got.ux);
            errors++;
          end
          if (got.uy !== exp_r.uy) begin
            $display("%0t: unit_y expected %h actual %h", $time, exp_r.uy, got.uy);
            errors++;
          end
          if (got.uz !== exp_r.uz) begin
            $display("%0t: unit_z expected %h actual %h", $time, exp_r.uz, got.uz);
            errors++;
          end
          if (got.mag !== exp_r.mag) begin
            $display("%0t: magnitude expected %h actual %h", $time, exp_r.mag, got.mag);
            errors++;
          end
          if (got.zero !== exp_r.zero) begin
            $display("%0t: was_zero expected %b actual %b", $time, exp_r.zero, got.zero);
            errors++;
          end
        end
      end
      if (long_hold_seen != long_hold_req) begin
        long_hold_seen = long_hold_req;
        sink_hold = 150;  // long enough to fill the pipe and stall the input
      end else if (sink_hold == 0 && !no_idle) begin
        sink_hold = pick_gap();
      end
      if (sink_hold > 0) begin
        sink_hold--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic logic [47:0] pack_vec(int x, int y, int z);
    logic [15:0] a, b, c;
    a = 16'(x);
    b = 16'(y);
    c = 16'(z);
    return {c, b, a};
  endfunction

  function automatic logic [15:0] rand_comp();
    int p;
    p = $urandom_range(99);
    if (p < 50) return 16'($urandom());
    if (p < 80) return 16'(int'($urandom_range(511)) - 256);  // small lengths
    if (p < 90) return 16'd0;
    return ($urandom_range(1)) ? 16'h8000 : 16'h7FFF;
  endfunction

  task automatic wait_all_done();
    while (vec_pending.size() > 0 || s_tvalid || norm_expected.size() > 0) @(posedge clk);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed: zero vector, axis extremes, most negative inputs, signs
    vec_pending.push_back(pack_vec(0, 0, 0));
    vec_pending.push_back(pack_vec(1, 0, 0));
    vec_pending.push_back(pack_vec(0, -1, 0));
    vec_pending.push_back(pack_vec(0, 0, 1));
    vec_pending.push_back(pack_vec(-32768, 0, 0));
    vec_pending.push_back(pack_vec(0, -32768, 0));
    vec_pending.push_back(pack_vec(0, 0, -32768));
    vec_pending.push_back(pack_vec(32767, 0, 0));
    vec_pending.push_back(pack_vec(-32768, -32768, -32768));
    vec_pending.push_back(pack_vec(32767, 32767, 32767));
    vec_pending.push_back(pack_vec(32767, -32768, 32767));
    vec_pending.push_back(pack_vec(-1, -1, -1));
    vec_pending.push_back(pack_vec(1, 1, 1));
    vec_pending.push_back(pack_vec(3, 4, 0));
    vec_pending.push_back(pack_vec(256, -256, 256));
    vec_pending.push_back(pack_vec(1, 32767, -1));
    vec_pending.push_back(pack_vec(-21845, 21845, 10922));
    vec_pending.push_back(pack_vec(0, 0, 0));
    wait_all_done();

    // burst while the sink holds off, so the block backs up
    no_idle = 1;
    long_hold_req++;
    for (int i = 0; i < 100; i++)
      vec_pending.push_back({rand_comp(), rand_comp(), rand_comp()});
    wait_all_done();
    no_idle = 0;

    // random phases, one of them with no idling on either side
    for (int ph = 0; ph < 5; ph++) begin
      no_idle = (ph == 2);
      for (int i = 0; i < 210; i++)
        vec_pending.push_back({rand_comp(), rand_comp(), rand_comp()});
      wait_all_done();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && norm_expected.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule

@@ files.f @@
rtl/core/vn3d_pkg.sv
rtl/core/vector_normalizer_3d_unit.sv
rtl/core/vn3d_checker.sv
test/tb_vector_normalizer_3d_unit.sv
